### src/brmsi_pkg.sv
// Shared types and decode constants for the banked ROM mapper with scanline interrupt.
package brmsi_pkg;

    // Request kinds carried on the action field
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Write address decode
    localparam logic [14:0] DECODE_MASK  = 15'h7003;
    localparam logic [14:0] ADDR_MIRROR  = 15'h0001;
    localparam logic [14:0] ADDR_COMMAND = 15'h2000;
    localparam logic [14:0] ADDR_BANK    = 15'h4000;
    localparam logic [14:0] ADDR_COUNTER = 15'h6003;

    // Bank select commands
    localparam logic [7:0] CMD_CHR_2K_A = 8'd0;
    localparam logic [7:0] CMD_CHR_1K_5 = 8'd1;
    localparam logic [7:0] CMD_CHR_2K_B = 8'd2;
    localparam logic [7:0] CMD_CHR_1K_7 = 8'd3;
    localparam logic [7:0] CMD_PRG_LO   = 8'd4;
    localparam logic [7:0] CMD_PRG_HI   = 8'd5;
    localparam logic [7:0] CMD_CHR_1K_4 = 8'd6;
    localparam logic [7:0] CMD_CHR_1K_6 = 8'd7;

    // Control from the request decode to the interrupt counter
    typedef struct packed {
        logic step;     // a stage moves into the result register this cycle
        logic load;     // counter write with nonzero data
        logic disarm;   // counter write with zero data
        logic tick;     // visible scanline tick
        logic blanked;  // rendering disabled on this tick
    } t_irq_ctl;

endpackage

### src/brmsi_irq.sv
// Scanline down-counter with arm flag and registered interrupt pulse.
module brmsi_irq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  brmsi_pkg::t_irq_ctl i_ctl,
    input  logic [7:0]          i_wdata,
    output logic                o_irq_pulse
);

    logic [7:0] r_counter;
    logic [7:0] n_counter;
    logic       r_armed;
    logic       n_armed;
    logic       r_pulse;
    logic       n_pulse;

    // Compute the next counter, arm flag and pulse for the request in flight
    always_comb begin
        n_counter = r_counter;
        n_armed   = r_armed;
        n_pulse   = 1'b0;
        if (i_ctl.load) begin
            n_counter = i_wdata;
            n_armed   = 1'b1;
        end else if (i_ctl.disarm) begin
            n_armed = 1'b0;
        end else if (i_ctl.tick) begin
            if (r_counter != 8'd0) begin
                n_counter = r_counter - 8'd1;
            end
            // fire when the count steps from one down to zero
            n_pulse = r_armed & ~i_ctl.blanked & (r_counter == 8'd1);
        end
    end

    // Advance only when the result register takes a new request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= 8'd0;
            r_armed   <= 1'b0;
            r_pulse   <= 1'b0;
        end else if (i_ctl.step) begin
            r_counter <= n_counter;
            r_armed   <= n_armed;
            r_pulse   <= n_pulse;
        end
    end

    assign o_irq_pulse = r_pulse;

endmodule

### src/banked_rom_mapper_scanline_irq.sv
// Top level: banked ROM mapper with bank registers and scanline interrupt counter.
//
// Usage: each input request is either a CPU write into cartridge space
// (i_action = 0) or an end-of-scanline tick (i_action = 1). A request is taken
// at a clock edge with i_valid high and o_stall low. Every request yields one
// result on o_valid/i_stall: the interrupt pulse for that request and the
// bank map as it stands after it.
// A request passes through the input register, then decode and state update
// into the result register. Throughput is one request per cycle while
// i_stall stays low; the interrupt counter and bank registers update in that one step.
// When the receiver stalls a waiting result, the result register holds, the
// input register fills, and o_stall rises only once both are occupied.
// Synchronous reset (i_rst_n low) empties both stages, sets vertical
// mirroring, command zero, a disarmed zero counter, the character banks
// 0,1,4,5,6,7 and the program banks at the last 32 KB of the ROM.
module banked_rom_mapper_scanline_irq #(
    parameter int LAST_VISIBLE_LINE = 239,
    parameter int PRG_CHUNKS_16K    = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [14:0] i_address,
    input  logic [7:0] i_wdata,
    input  logic [8:0] i_line_number,
    input  logic       i_blanked,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_irq_pulse,
    output logic       o_mirror_horizontal,
    output logic [7:0] o_prg_bank_lo,
    output logic [7:0] o_prg_bank_hi,
    output logic [6:0] o_chr_bank_2k_a,
    output logic [6:0] o_chr_bank_2k_b,
    output logic [7:0] o_chr_bank_1k_4,
    output logic [7:0] o_chr_bank_1k_5,
    output logic [7:0] o_chr_bank_1k_6,
    output logic [7:0] o_chr_bank_1k_7
);

    localparam int          PRG_BASE    = 4 * ((PRG_CHUNKS_16K - 1) >> 1);
    localparam logic [7:0]  PRG_RST_LO  = 8'(PRG_BASE);
    localparam logic [7:0]  PRG_RST_HI  = 8'(PRG_BASE + 1);
    localparam logic [8:0]  LAST_LINE   = 9'(LAST_VISIBLE_LINE);

    // Input register
    logic        r_in_valid;
    logic        r_in_action;
    logic [14:0] r_in_address;
    logic [7:0]  r_in_wdata;
    logic [8:0]  r_in_line;
    logic        r_in_blanked;

    // Result stage and mapper state
    logic       r_out_valid;
    logic [7:0] r_cmd;
    logic       r_mirror;
    logic [7:0] r_prg_lo;
    logic [7:0] r_prg_hi;
    logic [6:0] r_chr_2k_a;
    logic [6:0] r_chr_2k_b;
    logic [7:0] r_chr_1k_4;
    logic [7:0] r_chr_1k_5;
    logic [7:0] r_chr_1k_6;
    logic [7:0] r_chr_1k_7;

    logic                advance;
    logic                step;
    logic                is_write;
    logic [14:0]         dec_addr;
    logic                wr_mirror;
    logic                wr_command;
    logic                wr_bank;
    logic                wr_counter;
    brmsi_pkg::t_irq_ctl irq_ctl;

    // Result register frees up when empty or drained this cycle
    assign advance = ~r_out_valid | ~i_stall;
    assign step    = advance & r_in_valid;
    assign o_stall = r_in_valid & ~advance;

    // Hold the input register while it cannot hand its request on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_action  <= i_action;
            r_in_address <= i_address;
            r_in_wdata   <= i_wdata;
            r_in_line    <= i_line_number;
            r_in_blanked <= i_blanked;
        end
    end

    // Decode the request
    assign is_write   = step & (r_in_action == brmsi_pkg::ACT_WRITE);
    assign dec_addr   = r_in_address & brmsi_pkg::DECODE_MASK;
    assign wr_mirror  = is_write & (dec_addr == brmsi_pkg::ADDR_MIRROR);
    assign wr_command = is_write & (dec_addr == brmsi_pkg::ADDR_COMMAND);
    assign wr_bank    = is_write & (dec_addr == brmsi_pkg::ADDR_BANK);
    assign wr_counter = is_write & (dec_addr == brmsi_pkg::ADDR_COUNTER);

    always_comb begin
        irq_ctl.step    = advance;
        irq_ctl.load    = wr_counter & (r_in_wdata != 8'd0);
        irq_ctl.disarm  = wr_counter & (r_in_wdata == 8'd0);
        irq_ctl.tick    = step & (r_in_action == brmsi_pkg::ACT_TICK)
                          & (r_in_line < LAST_LINE);
        irq_ctl.blanked = r_in_blanked;
    end

    brmsi_irq u_irq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (irq_ctl),
        .i_wdata     (r_in_wdata),
        .o_irq_pulse (o_irq_pulse)
    );

    // Track result occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    // Update mirroring, command and bank registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd      <= 8'd0;
            r_mirror   <= 1'b0;
            r_prg_lo   <= PRG_RST_LO;
            r_prg_hi   <= PRG_RST_HI;
            r_chr_2k_a <= 7'd0;
            r_chr_2k_b <= 7'd1;
            r_chr_1k_4 <= 8'd4;
            r_chr_1k_5 <= 8'd5;
            r_chr_1k_6 <= 8'd6;
            r_chr_1k_7 <= 8'd7;
        end else begin
            if (wr_mirror) begin
                r_mirror <= r_in_wdata[0];
            end
            if (wr_command) begin
                r_cmd <= r_in_wdata;
            end
            if (wr_bank) begin
                case (r_cmd)
                    brmsi_pkg::CMD_CHR_2K_A: r_chr_2k_a <= r_in_wdata[7:1];
                    brmsi_pkg::CMD_CHR_1K_5: r_chr_1k_5 <= r_in_wdata;
                    brmsi_pkg::CMD_CHR_2K_B: r_chr_2k_b <= r_in_wdata[7:1];
                    brmsi_pkg::CMD_CHR_1K_7: r_chr_1k_7 <= r_in_wdata;
                    brmsi_pkg::CMD_PRG_LO:   r_prg_lo   <= r_in_wdata;
                    brmsi_pkg::CMD_PRG_HI:   r_prg_hi   <= r_in_wdata;
                    brmsi_pkg::CMD_CHR_1K_4: r_chr_1k_4 <= r_in_wdata;
                    brmsi_pkg::CMD_CHR_1K_6: r_chr_1k_6 <= r_in_wdata;
                    default: begin
                        // drop loads under an unknown command
                    end
                endcase
            end
        end
    end

    // Drive the result from the state as left by the last request
    assign o_valid             = r_out_valid;
    assign o_mirror_horizontal = r_mirror;
    assign o_prg_bank_lo       = r_prg_lo;
    assign o_prg_bank_hi       = r_prg_hi;
    assign o_chr_bank_2k_a     = r_chr_2k_a;
    assign o_chr_bank_2k_b     = r_chr_2k_b;
    assign o_chr_bank_1k_4     = r_chr_1k_4;
    assign o_chr_bank_1k_5     = r_chr_1k_5;
    assign o_chr_bank_1k_6     = r_chr_1k_6;
    assign o_chr_bank_1k_7     = r_chr_1k_7;

`ifndef SYNTH
    // a pulse belongs to a delivered result
    a_pulse_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_irq_pulse |-> o_valid)
        else $error("irq pulse without a valid result");

    // the input side backs up only behind a stalled, full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && r_in_valid))
        else $error("input stalled without a full pipeline");

    // a stalled result keeps its bank map
    a_hold_banks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_prg_bank_lo) && $stable(o_chr_bank_2k_a)
                                  && $stable(o_irq_pulse) && o_valid))
        else $error("stalled result changed");
`endif

endmodule

### verif/tb_top.sv
// Self-checking testbench for the banked ROM mapper with scanline interrupt counter.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAST_VISIBLE_LINE = 239;
    localparam int PRG_CHUNKS_16K    = 16;
    localparam int RANDOM_REQUESTS   = 600;
    localparam int IDLE_LIMIT        = 2000;
    localparam int DRAIN_CYCLES      = 8;

    typedef struct packed {
        logic        action;
        logic [14:0] address;
        logic [7:0]  wdata;
        logic [8:0]  line_number;
        logic        blanked;
    } t_mapper_request;

    typedef struct packed {
        logic       irq_pulse;
        logic       mirror_horizontal;
        logic [7:0] prg_bank_lo;
        logic [7:0] prg_bank_hi;
        logic [6:0] chr_bank_2k_a;
        logic [6:0] chr_bank_2k_b;
        logic [7:0] chr_bank_1k_4;
        logic [7:0] chr_bank_1k_5;
        logic [7:0] chr_bank_1k_6;
        logic [7:0] chr_bank_1k_7;
    } t_bank_map;

    // Tracks the mapper state and queues the bank map each request should produce
    class t_bank_map_scoreboard;
        logic       mirror_bit;
        logic [7:0] command_sel;
        logic [7:0] line_count;
        logic       irq_armed;
        logic [7:0] prg_lo, prg_hi;
        logic [7:0] chr_2k_a, chr_2k_b, chr_1k_4, chr_1k_5, chr_1k_6, chr_1k_7;
        t_bank_map  expected_maps[$];
        int         failures;
        int         writes_seen;
        int         ticks_seen;
        int         pulses_due;

        function new();
            mirror_bit  = 1'b0;
            command_sel = 8'd0;
            line_count  = 8'd0;
            irq_armed   = 1'b0;
            prg_lo      = 8'(4 * ((PRG_CHUNKS_16K - 1) >> 1));
            prg_hi      = 8'(4 * ((PRG_CHUNKS_16K - 1) >> 1) + 1);
            chr_2k_a    = 8'd0;
            chr_2k_b    = 8'd1;
            chr_1k_4    = 8'd4;
            chr_1k_5    = 8'd5;
            chr_1k_6    = 8'd6;
            chr_1k_7    = 8'd7;
            failures    = 0;
            writes_seen = 0;
            ticks_seen  = 0;
            pulses_due  = 0;
        endfunction

        // Load the bank that the current command selects; drop unknown commands
        function void load_bank(logic [7:0] d);
            case (command_sel)
                brmsi_pkg::CMD_CHR_2K_A: chr_2k_a = d >> 1;
                brmsi_pkg::CMD_CHR_1K_5: chr_1k_5 = d;
                brmsi_pkg::CMD_CHR_2K_B: chr_2k_b = d >> 1;
                brmsi_pkg::CMD_CHR_1K_7: chr_1k_7 = d;
                brmsi_pkg::CMD_PRG_LO:   prg_lo   = d;
                brmsi_pkg::CMD_PRG_HI:   prg_hi   = d;
                brmsi_pkg::CMD_CHR_1K_4: chr_1k_4 = d;
                brmsi_pkg::CMD_CHR_1K_6: chr_1k_6 = d;
                default: ;
            endcase
        endfunction

        function void note_request(t_mapper_request r);
            t_bank_map  want;
            logic [7:0] prior;
            logic       pulse;
            pulse = 1'b0;
            if (r.action == brmsi_pkg::ACT_WRITE) begin
                writes_seen++;
                case (r.address & brmsi_pkg::DECODE_MASK)
                    brmsi_pkg::ADDR_MIRROR:  mirror_bit  = r.wdata[0];
                    brmsi_pkg::ADDR_COMMAND: command_sel = r.wdata;
                    brmsi_pkg::ADDR_BANK:    load_bank(r.wdata);
                    brmsi_pkg::ADDR_COUNTER: begin
                        if (r.wdata != 8'd0) begin
                            line_count = r.wdata;
                            irq_armed  = 1'b1;
                        end else begin
                            irq_armed = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end else begin
                ticks_seen++;
                // Count down on visible lines only; a zero counter stays at zero
                if (r.line_number < LAST_VISIBLE_LINE) begin
                    prior = line_count;
                    if (line_count != 8'd0)
                        line_count = line_count - 8'd1;
                    pulse = irq_armed && !r.blanked && line_count == 8'd0 && prior != 8'd0;
                end
            end
            if (pulse)
                pulses_due++;
            want = '{pulse, mirror_bit, prg_lo, prg_hi, chr_2k_a[6:0], chr_2k_b[6:0],
                     chr_1k_4, chr_1k_5, chr_1k_6, chr_1k_7};
            expected_maps.push_back(want);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(t_bank_map got);
            t_bank_map want;
            if (expected_maps.size() == 0) begin
                $error("result arrived with no request outstanding");
                failures++;
                return;
            end
            want = expected_maps.pop_front();
            compare_field("irq_pulse", want.irq_pulse, got.irq_pulse);
            compare_field("mirror_horizontal", want.mirror_horizontal, got.mirror_horizontal);
            compare_field("prg_bank_lo", want.prg_bank_lo, got.prg_bank_lo);
            compare_field("prg_bank_hi", want.prg_bank_hi, got.prg_bank_hi);
            compare_field("chr_bank_2k_a", want.chr_bank_2k_a, got.chr_bank_2k_a);
            compare_field("chr_bank_2k_b", want.chr_bank_2k_b, got.chr_bank_2k_b);
            compare_field("chr_bank_1k_4", want.chr_bank_1k_4, got.chr_bank_1k_4);
            compare_field("chr_bank_1k_5", want.chr_bank_1k_5, got.chr_bank_1k_5);
            compare_field("chr_bank_1k_6", want.chr_bank_1k_6, got.chr_bank_1k_6);
            compare_field("chr_bank_1k_7", want.chr_bank_1k_7, got.chr_bank_1k_7);
        endfunction

        function void flag_leftovers();
            if (expected_maps.size() != 0) begin
                $error("%0d results never arrived", expected_maps.size());
                failures += expected_maps.size();
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_action;
    logic [14:0] i_address;
    logic [7:0]  i_wdata;
    logic [8:0]  i_line_number;
    logic        i_blanked;
    logic        o_valid;
    logic        i_stall;
    logic        o_irq_pulse;
    logic        o_mirror_horizontal;
    logic [7:0]  o_prg_bank_lo;
    logic [7:0]  o_prg_bank_hi;
    logic [6:0]  o_chr_bank_2k_a;
    logic [6:0]  o_chr_bank_2k_b;
    logic [7:0]  o_chr_bank_1k_4;
    logic [7:0]  o_chr_bank_1k_5;
    logic [7:0]  o_chr_bank_1k_6;
    logic [7:0]  o_chr_bank_1k_7;

    t_bank_map            result_bus;
    t_bank_map_scoreboard sb;
    int                   burst_left = 0;
    int                   requests_sent = 0;
    int                   stall_mode = 0;
    int                   stall_left = 0;
    int                   idle_cycles = 0;

    banked_rom_mapper_scanline_irq #(
        .LAST_VISIBLE_LINE (LAST_VISIBLE_LINE),
        .PRG_CHUNKS_16K    (PRG_CHUNKS_16K)
    ) u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_action            (i_action),
        .i_address           (i_address),
        .i_wdata             (i_wdata),
        .i_line_number       (i_line_number),
        .i_blanked           (i_blanked),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_irq_pulse         (o_irq_pulse),
        .o_mirror_horizontal (o_mirror_horizontal),
        .o_prg_bank_lo       (o_prg_bank_lo),
        .o_prg_bank_hi       (o_prg_bank_hi),
        .o_chr_bank_2k_a     (o_chr_bank_2k_a),
        .o_chr_bank_2k_b     (o_chr_bank_2k_b),
        .o_chr_bank_1k_4     (o_chr_bank_1k_4),
        .o_chr_bank_1k_5     (o_chr_bank_1k_5),
        .o_chr_bank_1k_6     (o_chr_bank_1k_6),
        .o_chr_bank_1k_7     (o_chr_bank_1k_7)
    );

    always #10 i_clk = ~i_clk;

    assign result_bus = {o_irq_pulse, o_mirror_horizontal, o_prg_bank_lo, o_prg_bank_hi,
                         o_chr_bank_2k_a, o_chr_bank_2k_b, o_chr_bank_1k_4,
                         o_chr_bank_1k_5, o_chr_bank_1k_6, o_chr_bank_1k_7};

    // Check accepted results and stall the output in runs of free, random and solid stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(result_bus);
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = (stall_mode == 2) ? $urandom_range(1, 30) : $urandom_range(5, 60);
        end
        stall_left--;
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 2) == 0);
            default: i_stall <= 1'b1;
        endcase
    end

    // End the run when neither side moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("banked_rom_mapper_scanline_irq regression: fail");
            $finish;
        end
    end

    // Present one request, holding it until accepted; open a gap, possibly empty, between bursts
    task automatic send_request(t_mapper_request r);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_action      <= r.action;
        i_address     <= r.address;
        i_wdata       <= r.wdata;
        i_line_number <= r.line_number;
        i_blanked     <= r.blanked;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(r);
        requests_sent++;
    endtask

    task automatic send_write(logic [14:0] addr, logic [7:0] data);
        t_mapper_request r;
        r = '{brmsi_pkg::ACT_WRITE, addr, data, 9'($urandom), 1'($urandom)};
        send_request(r);
    endtask

    task automatic send_tick(logic [8:0] line, logic blank);
        t_mapper_request r;
        r = '{brmsi_pkg::ACT_TICK, 15'($urandom), 8'($urandom), line, blank};
        send_request(r);
    endtask

    // Set random bits outside the decode mask so aliases hit the same register
    function automatic logic [14:0] alias_of(logic [14:0] base);
        return base | (15'($urandom) & ~brmsi_pkg::DECODE_MASK);
    endfunction

    initial begin
        int pick;
        int run;
        logic [7:0] cmd;
        logic [7:0] count;
        t_mapper_request noise;

        sb            = new();
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_action      = brmsi_pkg::ACT_WRITE;
        i_address     = '0;
        i_wdata       = '0;
        i_line_number = '0;
        i_blanked     = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: mirroring, aliased decode, unmatched address
        send_write(brmsi_pkg::ADDR_MIRROR, 8'hFF);
        send_write(15'h0FFD, 8'h00);
        send_write(15'h7FFF, 8'hFF);
        // Directed: every bank command with one data extreme (all ones on even, zero on odd), then an unknown command
        for (int c = 0; c < 8; c++) begin
            send_write(brmsi_pkg::ADDR_COMMAND, 8'(c));
            send_write(brmsi_pkg::ADDR_BANK, c[0] ? 8'h00 : 8'hFF);
        end
        send_write(brmsi_pkg::ADDR_COMMAND, 8'hFF);
        send_write(brmsi_pkg::ADDR_BANK, 8'h55);
        // Directed: interrupt fire, invisible line, blanked suppression, disarm, zero reload
        send_write(brmsi_pkg::ADDR_COUNTER, 8'd1);
        send_tick(9'(LAST_VISIBLE_LINE - 1), 1'b0);
        send_tick(9'(LAST_VISIBLE_LINE), 1'b0);
        send_tick(9'h1FF, 1'b0);
        send_write(brmsi_pkg::ADDR_COUNTER, 8'd1);
        send_tick(9'd0, 1'b1);
        send_write(brmsi_pkg::ADDR_COUNTER, 8'd0);
        send_tick(9'd0, 1'b0);

        // Random: mostly well-formed command/load pairs and armed tick runs, some noise
        while (requests_sent < RANDOM_REQUESTS) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                cmd = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(8, 255))
                                                  : 8'($urandom_range(0, 7));
                send_write(alias_of(brmsi_pkg::ADDR_COMMAND), cmd);
                send_write(alias_of(brmsi_pkg::ADDR_BANK), 8'($urandom));
            end else if (pick < 38) begin
                send_write(alias_of(brmsi_pkg::ADDR_MIRROR), 8'($urandom));
            end else if (pick < 50) begin
                case ($urandom_range(0, 9))
                    0:       count = 8'd0;
                    1:       count = 8'($urandom);
                    default: count = 8'($urandom_range(1, 6));
                endcase
                send_write(alias_of(brmsi_pkg::ADDR_COUNTER), count);
            end else if (pick < 90) begin
                run = $urandom_range(1, 8);
                for (int k = 0; k < run; k++) begin
                    if ($urandom_range(0, 7) == 0)
                        send_tick(9'($urandom_range(0, 511)), ($urandom_range(0, 5) == 0));
                    else
                        send_tick(9'($urandom_range(0, LAST_VISIBLE_LINE - 1)),
                                  ($urandom_range(0, 5) == 0));
                end
            end else begin
                noise = t_mapper_request'({$urandom, $urandom});
                send_request(noise);
            end
        end
        i_valid <= 1'b0;

        // Drain outstanding results, then allow the pipeline to settle
        while (sb.expected_maps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.flag_leftovers();

        $display("Covered %0d requests: %0d bus writes and %0d scanline ticks.",
                 requests_sent, sb.writes_seen, sb.ticks_seen);
        $display("Interrupt pulses predicted: %0d; mismatches: %0d.",
                 sb.pulses_due, sb.failures);
        if (sb.failures == 0)
            $display("banked_rom_mapper_scanline_irq regression: pass");
        else
            $display("banked_rom_mapper_scanline_irq regression: fail");
        $finish;
    end

endmodule
